>>> rtl/core/rigid_body_2d_integrator_assert.svh
// Assertion macros shared by the rigid body integrator RTL.
`ifndef RIGID_BODY_2D_INTEGRATOR_ASSERT_SVH
`define RIGID_BODY_2D_INTEGRATOR_ASSERT_SVH

// Clocked check, masked while reset is active.
`define RB2D_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check, also evaluated during reset.
`define RB2D_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/rb2d_pkg.sv
// Constants and helpers for the planar rigid body integrator.
`default_nettype none
package rb2d_pkg;

	localparam int unsigned ANGLE_PI     = 205887;
	localparam int unsigned ANGLE_TWO_PI = 411775;
	localparam int unsigned SNAP_LIN_SQ  = 4295;
	localparam int unsigned SNAP_ANG     = 66;

	// Command codes
	localparam logic [1:0] CMD_FORCE = 2'd0;
	localparam logic [1:0] CMD_POINT = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_PLACE = 2'd3;

	// Register indexes
	localparam logic [2:0] REG_GRAV_X  = 3'd0;
	localparam logic [2:0] REG_GRAV_Y  = 3'd1;
	localparam logic [2:0] REG_INV_M   = 3'd2;
	localparam logic [2:0] REG_INV_I   = 3'd3;
	localparam logic [2:0] REG_LDAMP   = 3'd4;
	localparam logic [2:0] REG_ADAMP   = 3'd5;
	localparam logic [2:0] REG_TSTEP   = 3'd6;
	localparam logic [2:0] REG_ENABLE  = 3'd7;

	// Clip to signed 32 bits; bit 32 flags a clip.
	function automatic logic [32:0] sat32(input logic signed [63:0] x);
		logic [32:0] r;
		if (x > 64'sd2147483647) begin
			r = {1'b1, 32'h7fff_ffff};
		end else if (x < -64'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, x[31:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/rigid_body_2d_integrator.sv
// Planar rigid body integrator: sequencer around one shared multiply-accumulate unit.
`default_nettype none
`include "rigid_body_2d_integrator_assert.svh"

// Semi-implicit Euler integrator for one planar body in Q16.16. Every word gives one
// result word. All products go through a single 33x33 signed multiplier whose output
// is registered, followed by one add-and-saturate step, so each product takes an
// issue step and an accumulate step. A rotation wrap is a compare-subtract unit that
// tries multiples of two pi from the largest down. A force at a point runs the torque
// products before the force add, and a disabled tick goes straight to the result. A new
// word is taken while the previous result still waits in the output register.
module rigid_body_2d_integrator (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// input channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          cmd,
	input  wire logic signed [31:0]  force_x,
	input  wire logic signed [31:0]  force_y,
	input  wire logic signed [31:0]  point_x,
	input  wire logic signed [31:0]  point_y,
	input  wire logic signed [18:0]  start_angle,
	// output channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [31:0]       pos_x,
	output logic signed [31:0]       pos_y,
	output logic signed [18:0]       angle,
	output logic signed [31:0]       vel_x,
	output logic signed [31:0]       vel_y,
	output logic signed [31:0]       spin,
	output logic signed [31:0]       net_accel_x,
	output logic signed [31:0]       net_accel_y,
	output logic signed [31:0]       spin_accel,
	output logic signed [31:0]       torque_used,
	output logic                     saturated,
	// configuration port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready
);

	// Sequencer states; product steps use a two-phase issue/accumulate
	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_T1    = 5'd1;
	localparam logic [4:0] ST_T2    = 5'd2;
	localparam logic [4:0] ST_AX    = 5'd3;
	localparam logic [4:0] ST_AY    = 5'd4;
	localparam logic [4:0] ST_AW    = 5'd5;
	localparam logic [4:0] ST_VX    = 5'd6;
	localparam logic [4:0] ST_VY    = 5'd7;
	localparam logic [4:0] ST_VW    = 5'd8;
	localparam logic [4:0] ST_DX    = 5'd9;
	localparam logic [4:0] ST_DY    = 5'd10;
	localparam logic [4:0] ST_DW    = 5'd11;
	localparam logic [4:0] ST_QX    = 5'd12;
	localparam logic [4:0] ST_QY    = 5'd13;
	localparam logic [4:0] ST_PX    = 5'd14;
	localparam logic [4:0] ST_PY    = 5'd15;
	localparam logic [4:0] ST_PR    = 5'd16;
	localparam logic [4:0] ST_ADDF  = 5'd17;
	localparam logic [4:0] ST_WRAP0 = 5'd18;
	localparam logic [4:0] ST_WRAP  = 5'd19;
	localparam logic [4:0] ST_WFIN  = 5'd20;
	localparam logic [4:0] ST_DONE  = 5'd21;

	localparam logic signed [35:0] TWO_PI_W = 36'(rb2d_pkg::ANGLE_TWO_PI);
	localparam logic signed [35:0] PI_W     = 36'(rb2d_pkg::ANGLE_PI);
	localparam logic [3:0]         WRAP_TOP = 4'd15;

	// configuration registers
	logic signed [31:0] grav_x_q, grav_y_q;
	logic [30:0]        inv_m_q, inv_i_q;
	logic [16:0]        ldamp_q, adamp_q, tstep_q;
	logic               enable_q;

	// motion state
	logic signed [31:0] px_q, py_q, rot_q, vx_q, vy_q, w_q;
	logic signed [31:0] fsx_q, fsy_q, tsum_q;
	logic signed [31:0] shown0_q, shown1_q, shown2_q, shown3_q;

	// latched input word
	logic signed [31:0] fx_q, fy_q, ipx_q, ipy_q;

	// sequencer
	logic [4:0]         state_q;
	logic               phase_q;
	logic               sat_q;
	logic signed [63:0] tmp_q;
	logic signed [35:0] wr_q;
	logic [3:0]         wk_q;
	logic               out_valid_q;

	// shared unit
	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] p_q;
	logic signed [63:0] sh64;
	logic signed [63:0] acc_sum;
	logic [32:0]        acc_val;
	logic signed [32:0] rx_w, ry_w;
	logic [63:0]        sq_w;
	logic signed [35:0] wr_sub;
	logic [4:0]         next_op;
	logic               out_free;
	logic               cfg_wr;
	logic [32:0]        acc_x_sat, acc_y_sat;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign out_free = !out_valid_q || !out_stall;

	assign rx_w = {ipx_q[31], ipx_q} - {px_q[31], px_q};
	assign ry_w = {ipy_q[31], ipy_q} - {py_q[31], py_q};
	assign sh64 = {{14{p_q[65]}}, p_q[65:16]};
	assign sq_w = p_q[63:0] + tmp_q;
	assign wr_sub = TWO_PI_W <<< wk_q;

	// register read
	always_comb begin
		case (paddr[4:2])
			rb2d_pkg::REG_GRAV_X: prdata = grav_x_q;
			rb2d_pkg::REG_GRAV_Y: prdata = grav_y_q;
			rb2d_pkg::REG_INV_M:  prdata = {1'b0, inv_m_q};
			rb2d_pkg::REG_INV_I:  prdata = {1'b0, inv_i_q};
			rb2d_pkg::REG_LDAMP:  prdata = {15'd0, ldamp_q};
			rb2d_pkg::REG_ADAMP:  prdata = {15'd0, adamp_q};
			rb2d_pkg::REG_TSTEP:  prdata = {15'd0, tstep_q};
			rb2d_pkg::REG_ENABLE: prdata = {31'd0, enable_q};
			default:              prdata = 32'd0;
		endcase
	end

	// multiplier operand select
	always_comb begin
		case (state_q)
			ST_T1: begin mul_a = rx_w; mul_b = {fy_q[31], fy_q}; end
			ST_T2: begin mul_a = ry_w; mul_b = {fx_q[31], fx_q}; end
			ST_AX: begin mul_a = {fsx_q[31], fsx_q}; mul_b = {2'b00, inv_m_q}; end
			ST_AY: begin mul_a = {fsy_q[31], fsy_q}; mul_b = {2'b00, inv_m_q}; end
			ST_AW: begin mul_a = {tsum_q[31], tsum_q}; mul_b = {2'b00, inv_i_q}; end
			ST_VX: begin mul_a = {shown0_q[31], shown0_q}; mul_b = {16'd0, tstep_q}; end
			ST_VY: begin mul_a = {shown1_q[31], shown1_q}; mul_b = {16'd0, tstep_q}; end
			ST_VW: begin mul_a = {shown2_q[31], shown2_q}; mul_b = {16'd0, tstep_q}; end
			ST_DX: begin mul_a = {vx_q[31], vx_q}; mul_b = {16'd0, ldamp_q}; end
			ST_DY: begin mul_a = {vy_q[31], vy_q}; mul_b = {16'd0, ldamp_q}; end
			ST_DW: begin mul_a = {w_q[31], w_q}; mul_b = {16'd0, adamp_q}; end
			ST_QX: begin mul_a = {vx_q[31], vx_q}; mul_b = {vx_q[31], vx_q}; end
			ST_QY: begin mul_a = {vy_q[31], vy_q}; mul_b = {vy_q[31], vy_q}; end
			ST_PX: begin mul_a = {vx_q[31], vx_q}; mul_b = {16'd0, tstep_q}; end
			ST_PY: begin mul_a = {vy_q[31], vy_q}; mul_b = {16'd0, tstep_q}; end
			ST_PR: begin mul_a = {w_q[31], w_q}; mul_b = {16'd0, tstep_q}; end
			default: begin mul_a = 33'sd0; mul_b = 33'sd0; end
		endcase
	end

	// accumulate select, then saturate
	always_comb begin
		case (state_q)
			ST_T2: acc_sum = 64'(tsum_q) + tmp_q - sh64;
			ST_AX: acc_sum = 64'(grav_x_q) + sh64;
			ST_AY: acc_sum = 64'(grav_y_q) + sh64;
			ST_VX: acc_sum = 64'(vx_q) + sh64;
			ST_VY: acc_sum = 64'(vy_q) + sh64;
			ST_VW: acc_sum = 64'(w_q) + sh64;
			ST_PX: acc_sum = 64'(px_q) + sh64;
			ST_PY: acc_sum = 64'(py_q) + sh64;
			ST_AW, ST_DX, ST_DY, ST_DW: acc_sum = sh64;
			default: acc_sum = 64'sd0;
		endcase
		acc_val = rb2d_pkg::sat32(acc_sum);
	end

	// step order
	always_comb begin
		case (state_q)
			ST_T1:   next_op = ST_T2;
			ST_T2:   next_op = ST_ADDF;
			ST_AX:   next_op = ST_AY;
			ST_AY:   next_op = ST_AW;
			ST_AW:   next_op = ST_VX;
			ST_VX:   next_op = ST_VY;
			ST_VY:   next_op = ST_VW;
			ST_VW:   next_op = ST_DX;
			ST_DX:   next_op = ST_DY;
			ST_DY:   next_op = ST_DW;
			ST_DW:   next_op = ST_QX;
			ST_QX:   next_op = ST_QY;
			ST_QY:   next_op = ST_PX;
			ST_PX:   next_op = ST_PY;
			ST_PY:   next_op = ST_PR;
			default: next_op = ST_WRAP0;
		endcase
	end

	// force accumulator adders
	always_comb begin
		acc_x_sat = rb2d_pkg::sat32(64'(fsx_q) + 64'(fx_q));
		acc_y_sat = rb2d_pkg::sat32(64'(fsy_q) + 64'(fy_q));
	end

	// product register
	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
	end

	// sequencer and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_x_q <= 32'sd0;
			grav_y_q <= -32'sd642253;
			inv_m_q <= 31'd65536;
			inv_i_q <= 31'd65536;
			ldamp_q <= 17'd65536;
			adamp_q <= 17'd65536;
			tstep_q <= 17'd1092;
			enable_q <= 1'b1;
			px_q <= '0; py_q <= '0; rot_q <= '0;
			vx_q <= '0; vy_q <= '0; w_q <= '0;
			fsx_q <= '0; fsy_q <= '0; tsum_q <= '0;
			shown0_q <= '0; shown1_q <= '0; shown2_q <= '0; shown3_q <= '0;
			fx_q <= '0; fy_q <= '0; ipx_q <= '0; ipy_q <= '0;
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
			sat_q <= 1'b0;
			tmp_q <= '0;
			wr_q <= '0;
			wk_q <= '0;
			out_valid_q <= 1'b0;
			pos_x <= '0; pos_y <= '0; angle <= '0;
			vel_x <= '0; vel_y <= '0; spin <= '0;
			net_accel_x <= '0; net_accel_y <= '0; spin_accel <= '0; torque_used <= '0;
			saturated <= 1'b0;
		end else begin
			// configuration write
			if (cfg_wr) begin
				case (paddr[4:2])
					rb2d_pkg::REG_GRAV_X: grav_x_q <= pwdata;
					rb2d_pkg::REG_GRAV_Y: grav_y_q <= pwdata;
					rb2d_pkg::REG_INV_M:  inv_m_q <= pwdata[30:0];
					rb2d_pkg::REG_INV_I:  inv_i_q <= pwdata[30:0];
					rb2d_pkg::REG_LDAMP:  ldamp_q <= pwdata[16:0];
					rb2d_pkg::REG_ADAMP:  adamp_q <= pwdata[16:0];
					rb2d_pkg::REG_TSTEP:  tstep_q <= pwdata[16:0];
					rb2d_pkg::REG_ENABLE: enable_q <= pwdata[0];
					default: ;
				endcase
			end

			// result word taken; the done step reloads it itself
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						fx_q <= force_x;
						fy_q <= force_y;
						ipx_q <= point_x;
						ipy_q <= point_y;
						sat_q <= 1'b0;
						phase_q <= 1'b0;
						case (cmd)
							rb2d_pkg::CMD_FORCE: state_q <= ST_ADDF;
							rb2d_pkg::CMD_POINT: state_q <= ST_T1;
							rb2d_pkg::CMD_TICK:  state_q <= enable_q ? ST_AX : ST_DONE;
							default: begin
								px_q <= point_x;
								py_q <= point_y;
								vx_q <= force_x;
								vy_q <= force_y;
								wr_q <= 36'(start_angle);
								state_q <= ST_WRAP0;
							end
						endcase
					end
				end
				ST_ADDF: begin
					// force accumulate with clipping
					fsx_q <= acc_x_sat[31:0];
					fsy_q <= acc_y_sat[31:0];
					sat_q <= sat_q | acc_x_sat[32] | acc_y_sat[32];
					state_q <= ST_DONE;
				end
				ST_WRAP0: begin
					// bias negative angles up by a multiple of two pi
					if (wr_q < 36'sd0) begin
						wr_q <= wr_q + (TWO_PI_W <<< WRAP_TOP);
					end
					wk_q <= WRAP_TOP;
					state_q <= ST_WRAP;
				end
				ST_WRAP: begin
					// one compare-subtract per cycle, largest multiple first
					if (wr_q >= wr_sub) begin
						wr_q <= wr_q - wr_sub;
					end
					if (wk_q == 4'd0) begin
						state_q <= ST_WFIN;
					end else begin
						wk_q <= wk_q - 4'd1;
					end
				end
				ST_WFIN: begin
					rot_q <= (wr_q > PI_W) ? 32'(wr_q - TWO_PI_W) : 32'(wr_q);
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						pos_x <= px_q;
						pos_y <= py_q;
						angle <= rot_q[18:0];
						vel_x <= vx_q;
						vel_y <= vy_q;
						spin <= w_q;
						net_accel_x <= shown0_q;
						net_accel_y <= shown1_q;
						spin_accel <= shown2_q;
						torque_used <= shown3_q;
						saturated <= sat_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					// product steps: issue, then accumulate
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						state_q <= next_op;
						sat_q <= sat_q | acc_val[32];
						case (state_q)
							ST_T1: tmp_q <= sh64;
							ST_T2: tsum_q <= acc_val[31:0];
							ST_AX: shown0_q <= acc_val[31:0];
							ST_AY: shown1_q <= acc_val[31:0];
							ST_AW: begin
								shown2_q <= acc_val[31:0];
								shown3_q <= tsum_q;
							end
							ST_VX, ST_DX: vx_q <= acc_val[31:0];
							ST_VY, ST_DY: vy_q <= acc_val[31:0];
							ST_VW, ST_DW: w_q <= acc_val[31:0];
							ST_QX: tmp_q <= p_q[63:0];
							ST_QY: begin
								// snap tiny velocities
								if (sq_w < 64'(rb2d_pkg::SNAP_LIN_SQ)) begin
									vx_q <= '0;
									vy_q <= '0;
								end
								if ((w_q < 32'sd66) && (w_q > -32'sd66)) begin
									w_q <= '0;
								end
							end
							ST_PX: px_q <= acc_val[31:0];
							ST_PY: py_q <= acc_val[31:0];
							ST_PR: begin
								wr_q <= 36'(64'(rot_q) + sh64);
								fsx_q <= '0;
								fsy_q <= '0;
								tsum_q <= '0;
							end
							default: ;
						endcase
					end
				end
			endcase
		end
	end

	// checks
	`RB2D_ASSERT(a_accept_idle, (in_valid && !in_stall) |-> (state_q == ST_IDLE), "word accepted while busy")
	`RB2D_ASSERT(a_done_holds, (state_q == ST_DONE && out_valid_q && out_stall) |=> (state_q == ST_DONE), "result overwritten while stalled")
	`RB2D_ASSERT(a_wrap_range, (state_q == ST_WFIN) |-> (wr_q >= 36'sd0 && wr_q < TWO_PI_W), "angle reduction out of range")
	`RB2D_ASSERT_ALWAYS(a_ready_cfg, pready, "pready dropped")

endmodule
`default_nettype wire

>>> verif/testbench.sv
// Testbench for the planar rigid body integrator: directed and random words checked against a predictor.
`default_nettype none
module testbench;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = rb2d_pkg::CMD_FORCE;
	logic signed [31:0] force_x = '0, force_y = '0, point_x = '0, point_y = '0;
	logic signed [18:0] start_angle = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] pos_x, pos_y, vel_x, vel_y, spin;
	logic signed [31:0] net_accel_x, net_accel_y, spin_accel, torque_used;
	logic signed [18:0] angle;
	logic saturated;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	rigid_body_2d_integrator dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// one result word
	typedef struct packed {
		logic signed [31:0] px, py;
		logic signed [18:0] ang;
		logic signed [31:0] vx, vy, w, ax, ay, aw, tq;
		logic sat;
	} body_state_t;

	body_state_t expected_states[$];
	int error_count = 0;

	// predictor copy of registers and state
	longint g_x, g_y, inv_m, inv_i, lin_damp, ang_damp, dt, enabled;
	longint p_x, p_y, rot, v_x, v_y, omega, f_x, f_y, trq;
	longint show_ax, show_ay, show_aw, show_tq;
	bit clipped;

	function automatic longint clip32(longint x);
		if (x > 64'sd2147483647) begin clipped = 1; return 64'sd2147483647; end
		if (x < -64'sd2147483648) begin clipped = 1; return -64'sd2147483648; end
		return x;
	endfunction

	function automatic longint fixmul(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic longint wrap_rot(longint r);
		longint m;
		m = r % longint'(rb2d_pkg::ANGLE_TWO_PI);
		if (m < 0) m += longint'(rb2d_pkg::ANGLE_TWO_PI);
		if (m > longint'(rb2d_pkg::ANGLE_PI)) m -= longint'(rb2d_pkg::ANGLE_TWO_PI);
		return m;
	endfunction

	function automatic void reset_body();
		g_x = 0; g_y = -642253; inv_m = 65536; inv_i = 65536;
		lin_damp = 65536; ang_damp = 65536; dt = 1092; enabled = 1;
		p_x = 0; p_y = 0; rot = 0; v_x = 0; v_y = 0; omega = 0;
		f_x = 0; f_y = 0; trq = 0; show_ax = 0; show_ay = 0; show_aw = 0; show_tq = 0;
	endfunction

	function automatic void set_register(logic [2:0] idx, logic [31:0] v);
		case (idx)
			rb2d_pkg::REG_GRAV_X: g_x = longint'($signed(v));
			rb2d_pkg::REG_GRAV_Y: g_y = longint'($signed(v));
			rb2d_pkg::REG_INV_M:  inv_m = longint'(v[30:0]);
			rb2d_pkg::REG_INV_I:  inv_i = longint'(v[30:0]);
			rb2d_pkg::REG_LDAMP:  lin_damp = longint'(v[16:0]);
			rb2d_pkg::REG_ADAMP:  ang_damp = longint'(v[16:0]);
			rb2d_pkg::REG_TSTEP:  dt = longint'(v[16:0]);
			rb2d_pkg::REG_ENABLE: enabled = longint'(v[0]);
			default: ;
		endcase
	endfunction

	function automatic body_state_t advance_body(logic [1:0] c, longint fx, longint fy,
			longint ptx, longint pty, longint sa);
		body_state_t r;
		longint ax, ay, aw, rx, ry;
		longint unsigned sq;
		clipped = 0;
		if (c == rb2d_pkg::CMD_FORCE || c == rb2d_pkg::CMD_POINT) begin
			if (c == rb2d_pkg::CMD_POINT) begin
				rx = ptx - p_x;
				ry = pty - p_y;
				trq = clip32(trq + fixmul(rx, fy) - fixmul(ry, fx));
			end
			f_x = clip32(f_x + fx);
			f_y = clip32(f_y + fy);
		end else if (c == rb2d_pkg::CMD_PLACE) begin
			p_x = ptx; p_y = pty; v_x = fx; v_y = fy; rot = wrap_rot(sa);
		end else if (enabled != 0) begin
			ax = clip32(g_x + fixmul(f_x, inv_m));
			ay = clip32(g_y + fixmul(f_y, inv_m));
			aw = clip32(fixmul(trq, inv_i));
			v_x = clip32(v_x + fixmul(ax, dt));
			v_y = clip32(v_y + fixmul(ay, dt));
			omega = clip32(omega + fixmul(aw, dt));
			v_x = clip32(fixmul(v_x, lin_damp));
			v_y = clip32(fixmul(v_y, lin_damp));
			omega = clip32(fixmul(omega, ang_damp));
			sq = longint'(v_x * v_x) + longint'(v_y * v_y);
			if (sq < rb2d_pkg::SNAP_LIN_SQ) begin v_x = 0; v_y = 0; end
			if (omega < longint'(rb2d_pkg::SNAP_ANG) && omega > -longint'(rb2d_pkg::SNAP_ANG))
				omega = 0;
			show_ax = ax; show_ay = ay; show_aw = aw; show_tq = trq;
			f_x = 0; f_y = 0; trq = 0;
			p_x = clip32(p_x + fixmul(v_x, dt));
			p_y = clip32(p_y + fixmul(v_y, dt));
			rot = wrap_rot(rot + fixmul(omega, dt));
		end
		r.px = 32'(p_x); r.py = 32'(p_y); r.ang = 19'(rot);
		r.vx = 32'(v_x); r.vy = 32'(v_y); r.w = 32'(omega);
		r.ax = 32'(show_ax); r.ay = 32'(show_ay); r.aw = 32'(show_aw); r.tq = 32'(show_tq);
		r.sat = clipped;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// sender burst state
	int burst_left = 0;

	// send one word; gaps between random-length bursts, valid stays up inside a burst
	task automatic send_word(logic [1:0] c, logic [31:0] fx, logic [31:0] fy,
			logic [31:0] ptx, logic [31:0] pty, logic [18:0] sa);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		expected_states.push_back(advance_body(c, $signed(fx), $signed(fy), $signed(ptx),
			$signed(pty), $signed(sa)));
		in_valid <= 1'b1; cmd <= c; force_x <= fx; force_y <= fy;
		point_x <= ptx; point_y <= pty; start_angle <= sa;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic write_register(logic [2:0] idx, logic [31:0] v);
		in_valid <= 1'b0;
		burst_left = 0;
		wait (expected_states.size() == 0);
		repeat (60) @(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		set_register(idx, v);
	endtask

	// receiver stall pattern
	int stall_mode = 0;
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	// result checker
	always @(posedge clk) begin
		body_state_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_states.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				e = expected_states.pop_front();
				if (pos_x !== e.px) report_mismatch("pos_x", pos_x, e.px);
				if (pos_y !== e.py) report_mismatch("pos_y", pos_y, e.py);
				if (angle !== e.ang) report_mismatch("angle", angle, e.ang);
				if (vel_x !== e.vx) report_mismatch("vel_x", vel_x, e.vx);
				if (vel_y !== e.vy) report_mismatch("vel_y", vel_y, e.vy);
				if (spin !== e.w) report_mismatch("spin", spin, e.w);
				if (net_accel_x !== e.ax) report_mismatch("net_accel_x", net_accel_x, e.ax);
				if (net_accel_y !== e.ay) report_mismatch("net_accel_y", net_accel_y, e.ay);
				if (spin_accel !== e.aw) report_mismatch("spin_accel", spin_accel, e.aw);
				if (torque_used !== e.tq) report_mismatch("torque_used", torque_used, e.tq);
				if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
			end
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 400000) - 200000;
			2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			default: return $urandom_range(0, 4000) - 2000;
		endcase
	endfunction

	function automatic logic [18:0] rand_angle();
		return 19'($urandom);
	endfunction

	// extremes, every command, wrap and snap cases
	task automatic test_directed();
		send_word(rb2d_pkg::CMD_TICK, 0, 0, 0, 0, 0);
		send_word(rb2d_pkg::CMD_FORCE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
		send_word(rb2d_pkg::CMD_FORCE, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
		send_word(rb2d_pkg::CMD_POINT, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 0);
		send_word(rb2d_pkg::CMD_POINT, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 0);
		send_word(rb2d_pkg::CMD_TICK, 0, 0, 0, 0, 0);
		send_word(rb2d_pkg::CMD_PLACE, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h8000_0000, 19'sd205887);
		send_word(rb2d_pkg::CMD_PLACE, 0, 0, 0, 0, 19'h40000);
		send_word(rb2d_pkg::CMD_PLACE, 0, 0, 0, 0, 19'h3ffff);
		send_word(rb2d_pkg::CMD_PLACE, 0, 0, 0, 0, -19'sd205887);
		send_word(rb2d_pkg::CMD_POINT, 32'h0001_0000, 0, 0, 32'h0100_0000, 0);
		send_word(rb2d_pkg::CMD_TICK, 0, 0, 0, 0, 0);
		send_word(rb2d_pkg::CMD_PLACE, 30, 40, 0, 0, 0);
		send_word(rb2d_pkg::CMD_TICK, 0, 0, 0, 0, 0);
		send_word(rb2d_pkg::CMD_PLACE, 32'hffff_ffff, 0, 5, 5, 19'sd100);
		send_word(rb2d_pkg::CMD_TICK, 0, 0, 0, 0, 0);
	endtask

	// register extremes with short random sequences
	task automatic test_registers();
		logic [31:0] vals [8][2];
		vals[0] = '{32'h7fff_ffff, 32'h8000_0000};
		vals[1] = '{32'h8000_0000, 32'h7fff_ffff};
		vals[2] = '{32'h7fff_ffff, 32'h0};
		vals[3] = '{32'h0, 32'h7fff_ffff};
		vals[4] = '{32'h0, 32'h1ffff};
		vals[5] = '{32'h1ffff, 32'h0};
		vals[6] = '{32'h1ffff, 32'h0};
		vals[7] = '{32'h0, 32'h1};
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < 8; i++) write_register(i[2:0], vals[i][s]);
			for (int n = 0; n < 20; n++)
				send_word(2'($urandom_range(0, 3)), rand_word(), rand_word(), rand_word(),
					rand_word(), rand_angle());
		end
	endtask

	// random settings and mostly well-formed force-then-tick sequences
	task automatic test_random();
		logic [1:0] c;
		for (int phase = 0; phase < 6; phase++) begin
			write_register(rb2d_pkg::REG_GRAV_X, $urandom_range(0, 200000) - 100000);
			write_register(rb2d_pkg::REG_GRAV_Y, phase == 0 ? -642253 : rand_word());
			write_register(rb2d_pkg::REG_INV_M, $urandom_range(0, 131072));
			write_register(rb2d_pkg::REG_INV_I, $urandom_range(0, 131072));
			write_register(rb2d_pkg::REG_LDAMP, $urandom_range(50000, 65536));
			write_register(rb2d_pkg::REG_ADAMP, $urandom_range(50000, 65536));
			write_register(rb2d_pkg::REG_TSTEP, $urandom_range(0, 4) == 0
				? $urandom_range(0, 131071) : $urandom_range(500, 8000));
			write_register(rb2d_pkg::REG_ENABLE, 32'($urandom_range(0, 4) != 0));
			for (int n = 0; n < 100; n++) begin
				c = ($urandom_range(0, 9) < 6) ? 2'($urandom_range(0, 1))
					: ($urandom_range(0, 5) == 0 ? rb2d_pkg::CMD_PLACE
					: rb2d_pkg::CMD_TICK);
				send_word(c, rand_word(), rand_word(), rand_word(), rand_word(),
					rand_angle());
			end
		end
	endtask

	initial begin
		reset_body();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_registers();
		test_random();
		in_valid <= 1'b0;
		wait (expected_states.size() == 0);
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
